// ===== sv/v6p_pkg.sv =====
package v6p_pkg;

  localparam int V6_LEN  = 16;
  localparam int V4_LEN  = 4;
  localparam int DEC_SAT = 256;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_GROUP,
    PH_COLON,
    PH_IPV4
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        legal;
  } out_item_t;

  typedef struct packed {
    logic [15:0][7:0] store;
    logic [4:0]       byte_pos;
    logic             gap_seen;
    logic [4:0]       gap_pos;
    logic [15:0]      hex_value;
    logic             hex_overflow;
    logic             group_digits;
    logic [8:0]       dec_value;
    logic             dec_only;
    logic [1:0]       octet_count;
    phase_t           phase;
    logic             error_seen;
  } parse_state_t;

  localparam parse_state_t ST_RESET = '{
    store:        '0,
    byte_pos:     '0,
    gap_seen:     1'b0,
    gap_pos:      '0,
    hex_value:    '0,
    hex_overflow: 1'b0,
    group_digits: 1'b0,
    dec_value:    '0,
    dec_only:     1'b1,
    octet_count:  '0,
    phase:        PH_START,
    error_seen:   1'b0
  };

  // clears the running group / octet accumulators
  function automatic parse_state_t new_group(input parse_state_t s);
    parse_state_t r;
    r = s;
    r.hex_value    = '0;
    r.hex_overflow = 1'b0;
    r.group_digits = 1'b0;
    r.dec_value    = '0;
    r.dec_only     = 1'b1;
    return r;
  endfunction

  // value * 10 + digit, saturating at 256
  function automatic logic [8:0] dec_accum(input logic [8:0] dv, input logic [3:0] d);
    logic [11:0] v;
    v = ({3'b0, dv} << 3) + ({3'b0, dv} << 1) + {8'b0, d};
    if (v > 12'(DEC_SAT)) begin
      return 9'(DEC_SAT);
    end
    return v[8:0];
  endfunction

endpackage

// ===== sv/v6p_char_step.sv =====
module v6p_char_step (
  input  v6p_pkg::parse_state_t cur,
  input  logic [7:0]            char_code,
  output v6p_pkg::parse_state_t nxt
);

  v6p_pkg::parse_state_t g;
  v6p_pkg::parse_state_t grp;
  logic        is_dec;
  logic        is_hex;
  logic        is_colon;
  logic [3:0]  hval;
  logic [19:0] hex_wide;
  logic [4:0]  pos_two;
  logic [5:0]  pos_end;
  logic [3:0]  v4_idx;

  always_comb begin
    is_dec   = char_code inside {[8'h30:8'h39]};
    is_hex   = 1'b1;
    is_colon = (char_code == v6p_pkg::CH_COLON);
    hval     = '0;
    if (is_dec) begin
      hval = char_code[3:0];
    end else if (char_code inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hval = char_code[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // one character inside a hex group (also entered from start and after a colon)
  always_comb begin
    g = cur;
    if (cur.phase == v6p_pkg::PH_COLON) begin
      g = v6p_pkg::new_group(cur);
    end
    g.phase  = v6p_pkg::PH_GROUP;
    grp      = g;
    hex_wide = {g.hex_value, hval};
    pos_two  = g.byte_pos + 5'd2;
    pos_end  = {1'b0, g.byte_pos} + 6'(v6p_pkg::V4_LEN);
    if (is_hex) begin
      grp.hex_value    = hex_wide[15:0];
      grp.group_digits = 1'b1;
      if (hex_wide[19:16] != 4'd0) begin
        grp.hex_overflow = 1'b1;
      end
      if (g.dec_only && is_dec) begin
        grp.dec_value = v6p_pkg::dec_accum(g.dec_value, hval);
      end else begin
        grp.dec_only = 1'b0;
      end
    end else if (is_colon) begin
      if (!g.group_digits || g.hex_overflow) begin
        grp.error_seen = 1'b1;
      end else begin
        grp.store[g.byte_pos[3:0]]        = g.hex_value[15:8];
        grp.store[g.byte_pos[3:0] + 4'd1] = g.hex_value[7:0];
        grp.byte_pos = pos_two;
        if (pos_two >= 5'(v6p_pkg::V6_LEN)) begin
          grp.error_seen = 1'b1;
        end else begin
          grp.phase = v6p_pkg::PH_COLON;
        end
      end
    end else if (char_code == v6p_pkg::CH_DOT) begin
      if (!g.group_digits || g.hex_overflow || !g.dec_only ||
          g.dec_value > 9'd255 ||
          (!g.gap_seen && g.byte_pos != 5'(v6p_pkg::V6_LEN - v6p_pkg::V4_LEN)) ||
          pos_end > 6'(v6p_pkg::V6_LEN)) begin
        grp.error_seen = 1'b1;
      end else begin
        grp.store[g.byte_pos[3:0]] = g.dec_value[7:0];
        grp = v6p_pkg::new_group(grp);
        grp.octet_count = 2'd1;
        grp.phase       = v6p_pkg::PH_IPV4;
      end
    end else begin
      grp.error_seen = 1'b1;
    end
  end

  always_comb begin
    nxt    = cur;
    v4_idx = cur.byte_pos[3:0] + {2'b0, cur.octet_count};
    if (!cur.error_seen) begin
      case (cur.phase)
        v6p_pkg::PH_START: begin
          if (is_colon) begin
            nxt.phase = v6p_pkg::PH_LEAD;
          end else begin
            nxt = grp;
          end
        end
        v6p_pkg::PH_LEAD: begin
          if (is_colon) begin
            nxt          = v6p_pkg::new_group(cur);
            nxt.gap_seen = 1'b1;
            nxt.gap_pos  = '0;
            nxt.phase    = v6p_pkg::PH_GROUP;
          end else begin
            nxt.error_seen = 1'b1;
          end
        end
        v6p_pkg::PH_COLON: begin
          if (is_colon) begin
            if (cur.gap_seen) begin
              nxt.error_seen = 1'b1;
            end else begin
              nxt          = g;
              nxt.gap_seen = 1'b1;
              nxt.gap_pos  = cur.byte_pos;
            end
          end else begin
            nxt = grp;
          end
        end
        v6p_pkg::PH_GROUP: begin
          nxt = grp;
        end
        v6p_pkg::PH_IPV4: begin
          if (is_dec) begin
            nxt.dec_value    = v6p_pkg::dec_accum(cur.dec_value, char_code[3:0]);
            nxt.group_digits = 1'b1;
          end else if (char_code == v6p_pkg::CH_DOT) begin
            if (!cur.group_digits || cur.dec_value > 9'd255 || cur.octet_count == 2'd3) begin
              nxt.error_seen = 1'b1;
            end else begin
              nxt.store[v4_idx] = cur.dec_value[7:0];
              nxt = v6p_pkg::new_group(nxt);
              nxt.octet_count = cur.octet_count + 2'd1;
            end
          end else begin
            nxt.error_seen = 1'b1;
          end
        end
        default: begin
          nxt.error_seen = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== sv/v6p_finish.sv =====
module v6p_finish (
  input  v6p_pkg::parse_state_t s,
  output v6p_pkg::out_item_t    res
);

  logic             err;
  logic [4:0]       bp;
  logic [15:0][7:0] store;
  logic [4:0]       gap_len;
  logic [5:0]       gap_end;
  logic [7:0]       full [16];

  always_comb begin
    err   = s.error_seen;
    bp    = s.byte_pos;
    store = s.store;
    if (!err) begin
      // close the open group or octet
      case (s.phase)
        v6p_pkg::PH_GROUP: begin
          if (s.group_digits) begin
            if (s.hex_overflow) begin
              err = 1'b1;
            end else begin
              store[bp[3:0]]        = s.hex_value[15:8];
              store[bp[3:0] + 4'd1] = s.hex_value[7:0];
              bp = bp + 5'd2;
            end
          end
        end
        v6p_pkg::PH_IPV4: begin
          if (s.octet_count != 2'd3 || !s.group_digits || s.dec_value > 9'd255) begin
            err = 1'b1;
          end else begin
            store[bp[3:0] + 4'd3] = s.dec_value[7:0];
            bp = bp + 5'(v6p_pkg::V4_LEN);
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
      if (bp < 5'(v6p_pkg::V6_LEN)) begin
        if (!s.gap_seen) begin
          err = 1'b1;
        end
      end else if (s.gap_seen) begin
        err = 1'b1;
      end
    end
  end

  // ellipsis expansion: bytes at and after the gap shift up by the missing count
  always_comb begin
    gap_len = (bp < 5'(v6p_pkg::V6_LEN)) ? 5'(v6p_pkg::V6_LEN) - bp : '0;
    gap_end = {1'b0, s.gap_pos} + {1'b0, gap_len};
    for (int k = 0; k < 16; k++) begin
      if (err) begin
        full[k] = '0;
      end else if (!s.gap_seen || 5'(k) < s.gap_pos) begin
        full[k] = store[k];
      end else if (6'(k) < gap_end) begin
        full[k] = '0;
      end else begin
        full[k] = store[4'(k) - gap_len[3:0]];
      end
    end
  end

  always_comb begin
    res.legal = !err;
    for (int k = 0; k < 8; k++) begin
      res.addr_high[63 - 8*k -: 8] = full[k];
      res.addr_low[63 - 8*k -: 8]  = full[k + 8];
    end
  end

endmodule

// ===== sv/ipv6_text_address_parser_core.sv =====
// ipv6 text address parser
// in channel: one character of the address text per transaction (in_data.char_code),
// with in_data.is_last set on the final character of the string.
// out channel: one transaction per string, sent after its last character:
// the 128-bit address as addr_high (bytes 0-7) and addr_low (bytes 8-15),
// big endian, and legal; an illegal string gives an all-zero address.
// a "::" is expanded when the string closes; an embedded dotted ipv4 tail is taken.
// throughput: one character per cycle while in_stall is low, set by the single state
// update that runs between the input register and the result register.
// the result is written to the output register when the last character leaves the input register.
// a stalled result holds in the output register while the next string keeps
// flowing in; only a second last character waits in the input register, which raises in_stall.
// reset (rst_n low, synchronous) empties both registers and returns the parse
// state to the start of a string.
module ipv6_text_address_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  v6p_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output v6p_pkg::out_item_t out_data
);

  v6p_pkg::in_item_t     in_r;
  logic                  in_valid_r;
  logic                  in_valid_nxt;
  v6p_pkg::parse_state_t st_r;
  v6p_pkg::parse_state_t st_nxt;
  v6p_pkg::parse_state_t st_step;
  v6p_pkg::out_item_t    out_r;
  v6p_pkg::out_item_t    out_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  slot_free;
  logic                  proceed;
  logic                  in_take;

  v6p_char_step u_step (
    .cur       (st_r),
    .char_code (in_r.char_code),
    .nxt       (st_step)
  );

  v6p_finish u_finish (
    .s   (st_step),
    .res (out_nxt)
  );

  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    proceed   = in_valid_r && (!in_r.is_last || slot_free);
    in_stall  = in_valid_r && !proceed;
    in_take   = in_valid && !in_stall;

    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (proceed) begin
      in_valid_nxt = 1'b0;
    end

    st_nxt = st_r;
    if (proceed) begin
      st_nxt = in_r.is_last ? v6p_pkg::ST_RESET : st_step;
    end

    out_valid_nxt = out_valid_r;
    if (proceed && in_r.is_last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= v6p_pkg::ST_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (proceed && in_r.is_last) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/v6p_checker.sv =====
module v6p_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input v6p_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input v6p_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an illegal string reports an all-zero address
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.legal |-> out_data.addr_high == 64'd0 && out_data.addr_low == 64'd0)
    else $error("illegal result with nonzero address");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result follows an accepted last character
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.is_last, 2))
    else $error("result without a closing character");

endmodule

bind ipv6_text_address_parser_core v6p_checker u_v6p_checker (.*);
